### sv/qrs_pkg.sv
package qrs_pkg;

    // Field widths.
    localparam int COEF_W = 16;
    localparam int ROOT_W = 32;
    localparam int STAT_W = 3;

    // Discriminant magnitude width (B*B - 4*A*C stays below 2^34 when not negative).
    localparam int D_W = 34;
    // Square root of D * 2^32 has this many bits.
    localparam int SQRT_W = 35;
    // Signed numerator width for the divide stages.
    localparam int NUM_W = 36;
    // Signed divisor width (2A or B).
    localparam int DEN_W = 18;

    localparam int SQRT_STAGES = SQRT_W;
    localparam int DIV_STAGES  = NUM_W;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [STAT_W-1:0] {
        ST_TWO    = 3'd0,
        ST_LINEAR = 3'd1,
        ST_INDET  = 3'd2,
        ST_IMPOSS = 3'd3,
        ST_NONE   = 3'd4
    } t_status;

    // One classified coefficient set, as it travels from the front to the back.
    typedef struct packed {
        t_status                   status;
        logic [D_W-1:0]            d;
        logic signed [COEF_W-1:0]  a;
        logic signed [COEF_W-1:0]  b;
        logic signed [COEF_W-1:0]  c;
    } t_job;

endpackage

### sv/qrs_in_if.sv
interface qrs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

### sv/qrs_out_if.sv
interface qrs_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] root_one;
    logic signed [31:0] root_two;
    logic               saturated;

    modport source (output valid, status, root_one, root_two, saturated, input ready);
    modport sink   (input valid, status, root_one, root_two, saturated, output ready);
endinterface

### sv/qrs_front.sv
module qrs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qrs_in_if.sink        i_coef,
    input  logic          i_full,
    output logic          o_push,
    output qrs_pkg::t_job o_job
);
    import qrs_pkg::*;

    logic                     r_fv;
    logic signed [COEF_W-1:0] r_a, r_b, r_c;
    logic signed [31:0]       r_bb, r_ac;
    logic signed [D_W:0]      w_disc;
    logic                     w_ready;
    t_status                  w_status;

    // The input register frees up whenever its content moves into the queue.
    assign w_ready      = !r_fv || !i_full;
    assign i_coef.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_ready) begin
            r_fv <= i_coef.valid;
        end
        if (w_ready && i_coef.valid) begin
            r_a  <= i_coef.coef_a;
            r_b  <= i_coef.coef_b;
            r_c  <= i_coef.coef_c;
            r_bb <= i_coef.coef_b * i_coef.coef_b;
            r_ac <= i_coef.coef_a * i_coef.coef_c;
        end
    end

    // Discriminant and classification of the registered set.
    assign w_disc = (D_W+1)'(r_bb) - ((D_W+1)'(r_ac) <<< 2);

    always_comb begin
        if (r_a == '0) begin
            if (r_b == '0) begin
                w_status = (r_c == '0) ? ST_INDET : ST_IMPOSS;
            end else begin
                w_status = ST_LINEAR;
            end
        end else if (w_disc[D_W]) begin
            w_status = ST_NONE;
        end else begin
            w_status = ST_TWO;
        end
    end

    assign o_push       = r_fv && !i_full;
    assign o_job.status = w_status;
    assign o_job.d      = (w_status == ST_TWO) ? w_disc[D_W-1:0] : '0;
    assign o_job.a      = r_a;
    assign o_job.b      = r_b;
    assign o_job.c      = r_c;

endmodule

### sv/qrs_queue.sv
module qrs_queue #(
    parameter int DEPTH = qrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  qrs_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output qrs_pkg::t_job o_job
);
    import qrs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    // Circular buffer with separate write and read pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // The queue takes a push while full only together with a pop, and never gives one while empty.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue pop while empty");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

### sv/qrs_sqrt.sv
module qrs_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  qrs_pkg::t_job              i_job,
    output logic                       o_valid,
    output qrs_pkg::t_job              o_job,
    output logic [qrs_pkg::SQRT_W-1:0] o_root
);
    import qrs_pkg::*;

    localparam int REM_W = SQRT_W + 3;

    logic              r_v    [SQRT_STAGES+1];
    t_job              r_job  [SQRT_STAGES+1];
    logic [REM_W-1:0]  r_rem  [SQRT_STAGES+1];
    logic [SQRT_W-1:0] r_root [SQRT_STAGES+1];

    // Stage zero takes the job with a cleared remainder and root.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_job[0]  <= i_job;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    // One root bit per stage; radicand is D followed by 32 zero bits.
    // The radicand is right aligned in 2*SQRT_W bits, so the pairs of D
    // enter from the third stage on.
    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
        logic [1:0]       w_pair;
        logic [REM_W-1:0] w_t, w_trial;
        logic             w_ge;

        if (i >= 2 && 2 * i < D_W + 4) begin : g_dbits
            assign w_pair = r_job[i].d[D_W+3-2*i -: 2];
        end else begin : g_zero
            assign w_pair = 2'b00;
        end

        assign w_t     = {r_rem[i][REM_W-3:0], w_pair};
        assign w_trial = REM_W'({r_root[i], 2'b01});
        assign w_ge    = (w_t >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
            if (i_en) begin
                r_job[i+1]  <= r_job[i];
                r_rem[i+1]  <= w_ge ? (w_t - w_trial) : w_t;
                r_root[i+1] <= {r_root[i][SQRT_W-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_v[SQRT_STAGES];
    assign o_job   = r_job[SQRT_STAGES];
    assign o_root  = r_root[SQRT_STAGES];

endmodule

### sv/qrs_div.sv
module qrs_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [qrs_pkg::NUM_W-1:0]  i_num,
    input  logic signed [qrs_pkg::DEN_W-1:0]  i_den,
    output logic signed [qrs_pkg::ROOT_W-1:0] o_quot,
    output logic                              o_sat
);
    import qrs_pkg::*;

    localparam int DV_W = DEN_W - 1;

    logic [NUM_W-1:0] r_num [DIV_STAGES+1];
    logic [DV_W-1:0]  r_dv  [DIV_STAGES+1];
    logic [DV_W-1:0]  r_rem [DIV_STAGES+1];
    logic             r_neg [DIV_STAGES+1];

    logic signed [NUM_W-1:0] w_nabs;
    logic signed [DEN_W-1:0] w_dabs;
    logic [NUM_W-1:0]        w_q, w_lim;

    assign w_nabs = i_num[NUM_W-1] ? -i_num : i_num;
    assign w_dabs = i_den[DEN_W-1] ? -i_den : i_den;

    // Stage zero splits off the signs and works on magnitudes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= w_nabs;
            r_dv[0]  <= w_dabs[DV_W-1:0];
            r_rem[0] <= '0;
            r_neg[0] <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        end
    end

    // Restoring division: one quotient bit per stage, shifted into the numerator word.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DV_W:0] w_t;
        logic          w_ge;

        assign w_t  = {r_rem[k], r_num[k][NUM_W-1]};
        assign w_ge = (w_t >= {1'b0, r_dv[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1] <= {r_num[k][NUM_W-2:0], w_ge};
                r_rem[k+1] <= w_ge ? DV_W'(w_t - {1'b0, r_dv[k]}) : w_t[DV_W-1:0];
                r_dv[k+1]  <= r_dv[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    // Apply the sign and clip to the signed Q16.16 range.
    assign w_q   = r_num[DIV_STAGES];
    assign w_lim = r_neg[DIV_STAGES] ? (NUM_W'(1) << (ROOT_W - 1))
                                     : (NUM_W'(1) << (ROOT_W - 1)) - 1'b1;
    assign o_sat = (w_q > w_lim);

    always_comb begin
        if (o_sat) begin
            o_quot = r_neg[DIV_STAGES] ? {1'b1, {(ROOT_W-1){1'b0}}}
                                       : {1'b0, {(ROOT_W-1){1'b1}}};
        end else if (r_neg[DIV_STAGES]) begin
            o_quot = -$signed(w_q[ROOT_W-1:0]);
        end else begin
            o_quot = $signed(w_q[ROOT_W-1:0]);
        end
    end

endmodule

### sv/quadratic_root_solver_unit.sv
// Throughput: one coefficient set per cycle; the square root and the two
// 37-stage dividers are fully pipelined and the back end advances whenever the
// output register is empty or being taken.
// Reset: synchronous, active low; it clears all valid flags and the queue pointers.
module quadratic_root_solver_unit #(
    parameter int QUEUE_DEPTH = qrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qrs_in_if.sink    i_coef,
    qrs_out_if.source o_root
);
    import qrs_pkg::*;

    logic              w_push, w_full, w_empty, w_pop, w_en;
    t_job              w_fjob, w_qjob, w_sjob;
    logic              w_sv;
    logic [SQRT_W-1:0] w_s;

    logic                     r_nv;
    t_status                  r_nstat;
    logic signed [NUM_W-1:0]  r_n1, r_n2;
    logic signed [DEN_W-1:0]  r_d1, r_d2;
    logic signed [NUM_W-1:0]  w_nb, w_sx;

    logic                     r_tv [DIV_STAGES+1];
    t_status                  r_ts [DIV_STAGES+1];
    logic signed [ROOT_W-1:0] w_q1, w_q2;
    logic                     w_s1, w_s2;

    logic                     r_o_valid;
    t_status                  r_o_status;
    logic signed [ROOT_W-1:0] r_o_one, r_o_two;
    logic                     r_o_sat;

    // The back end moves whenever the output register can take a new result.
    assign w_en  = !r_o_valid || o_root.ready;
    assign w_pop = w_en && !w_empty;

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (i_coef),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_fjob)
    );

    qrs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_qjob)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pop),
        .i_job   (w_qjob),
        .o_valid (w_sv),
        .o_job   (w_sjob),
        .o_root  (w_s)
    );

    // Build the numerators and divisors for both roots.
    assign w_nb = -(NUM_W'(w_sjob.b) <<< 16);
    assign w_sx = $signed({1'b0, w_s});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= 1'b0;
        end else if (w_en) begin
            r_nv <= w_sv;
        end
        if (w_en) begin
            r_nstat <= w_sjob.status;
            if (w_sjob.status == ST_LINEAR) begin
                r_n1 <= -(NUM_W'(w_sjob.c) <<< 16);
                r_d1 <= DEN_W'(w_sjob.b);
            end else begin
                r_n1 <= w_nb + w_sx;
                r_d1 <= DEN_W'(w_sjob.a) <<< 1;
            end
            r_n2 <= w_nb - w_sx;
            r_d2 <= DEN_W'(w_sjob.a) <<< 1;
        end
    end

    qrs_div u_div_one (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_n1),
        .i_den  (r_d1),
        .o_quot (w_q1),
        .o_sat  (w_s1)
    );

    qrs_div u_div_two (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r_n2),
        .i_den  (r_d2),
        .o_quot (w_q2),
        .o_sat  (w_s2)
    );

    // Valid and status ride alongside the divider stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv[0] <= 1'b0;
        end else if (w_en) begin
            r_tv[0] <= r_nv;
        end
        if (w_en) begin
            r_ts[0] <= r_nstat;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_tag
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tv[k+1] <= 1'b0;
            end else if (w_en) begin
                r_tv[k+1] <= r_tv[k];
            end
            if (w_en) begin
                r_ts[k+1] <= r_ts[k];
            end
        end
    end

    // Output register; roots that the status does not use are forced to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_tv[DIV_STAGES];
        end
        if (w_en) begin
            r_o_status <= r_ts[DIV_STAGES];
            case (r_ts[DIV_STAGES])
                ST_TWO: begin
                    r_o_one <= w_q1;
                    r_o_two <= w_q2;
                    r_o_sat <= w_s1 || w_s2;
                end
                ST_LINEAR: begin
                    r_o_one <= w_q1;
                    r_o_two <= '0;
                    r_o_sat <= w_s1;
                end
                default: begin
                    r_o_one <= '0;
                    r_o_two <= '0;
                    r_o_sat <= 1'b0;
                end
            endcase
        end
    end

    assign o_root.valid     = r_o_valid;
    assign o_root.status    = r_o_status;
    assign o_root.root_one  = r_o_one;
    assign o_root.root_two  = r_o_two;
    assign o_root.saturated = r_o_sat;

    // Only two-root and linear results carry roots or a clip flag.
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != ST_TWO && r_o_status != ST_LINEAR)
            |-> (r_o_one == '0 && r_o_two == '0 && !r_o_sat))
        else $error("nonzero root for a status without roots");
    a_linear_one_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_LINEAR) |-> r_o_two == '0)
        else $error("second root set on a linear result");
    a_stall_freezes_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_tv[DIV_STAGES]) && $stable(r_nv))
        else $error("back end moved while the output was stalled");

endmodule
